// ===== rtl/sem_pkg.sv =====
// Shared constants, register codes and result type of the Sobel edge-magnitude block.
// No dependencies; used by sem_out_fifo and sobel_edge_magnitude_3x3.
package sem_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int PIX_W          = 8;
    localparam int LINE_WIDTH_W   = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int MIN_DIM        = 3;
    localparam int SUM_W          = PIX_W + 2;
    localparam int SAT_MAX        = 255;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             last_in_frame;
    } sem_result_t;

endpackage

// ===== rtl/sem_line_ram.sv =====
// Simple dual-port synchronous RAM holding the two previous rows, one column per word.
// No package dependency; one write port, one registered read port.
module sem_line_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sem_out_fifo.sv =====
// Small result queue between the filter pipeline and the output channel.
// Depends on sem_pkg for the result type and queue depth.
module sem_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  sem_pkg::sem_result_t          push_data,
    input  logic                          pop,
    output sem_pkg::sem_result_t          pop_data,
    output logic [sem_pkg::FIFO_CNT_W-1:0] count
);
    import sem_pkg::*;

    sem_result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// Sobel 3x3 edge magnitude over a raster pixel stream: one pixel per clock while the output keeps up.
// A pixel is taken, the line store is read at its column, and the next cycle
// forms |Gx|+|Gy| (saturated to 255) and writes the column back, so the line store port
// sets the rate at one transfer per clock. A result enters the output queue in the cycle
// after its pixel is accepted and can be transferred out at the following edge. The input
// is held off only while the queued results plus the one in flight reach three, which
// happens only when the output side stalls. Border pixels (first two rows and columns)
// give no result; the final result of a frame carries last_in_frame. The line store is
// not cleared after reset.
// Depends on sem_pkg, sem_line_ram and sem_out_fifo.
module sobel_edge_magnitude_3x3 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sem_pkg::PIX_W-1:0]          s_pixel,
    input  logic                               s_frame_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sem_pkg::PIX_W-1:0]          m_edge_res,
    output logic                               m_last_in_frame
);
    import sem_pkg::*;

    localparam int LINE_W = 2 * PIX_W;

    logic [LINE_WIDTH_W-1:0]   line_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [COL_W:0]            w_eff;
    logic [ROW_W:0]            h_eff;

    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_next;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             restart;
    logic             col_last;
    logic             row_last;
    logic             s_accept;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;

    logic [LINE_W-1:0] ram_q;
    logic [LINE_W-1:0] line_q;
    logic [LINE_W-1:0] wr_word;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [PIX_W-1:0] t0_reg, m0_reg, b0_reg, t1_reg, m1_reg, b1_reg;
    logic [PIX_W-1:0] t2, m2, b2;
    logic [SUM_W-1:0] gx_a, gx_b, gy_a, gy_b, abs_x, abs_y;
    logic [SUM_W:0]   mag;

    sem_result_t           res;
    sem_result_t           out_data;
    logic                  res_push;
    logic                  res_pop;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] pending;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_W'(640);
            frame_height_reg <= FRAME_HEIGHT_W'(480);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[LINE_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (line_width_reg < MIN_DIM) begin
            w_eff = (COL_W+1)'(MIN_DIM);
        end else if (line_width_reg > MAX_WIDTH) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(line_width_reg);
        end
        if (frame_height_reg < MIN_DIM) begin
            h_eff = (ROW_W+1)'(MIN_DIM);
        end else if (frame_height_reg > MAX_HEIGHT) begin
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W+1)'(frame_height_reg);
        end
    end

    // input stage: position of the incoming pixel
    assign pending  = fifo_count + FIFO_CNT_W'(s1_valid_reg);
    assign s_ready  = (pending < FIFO_CNT_W'(FIFO_DEPTH - 1));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        restart = s_frame_start || ({1'b0, col_count_reg} >= w_eff)
                  || ({1'b0, row_count_reg} >= h_eff);
        c_cur    = restart ? '0 : col_count_reg;
        r_cur    = restart ? '0 : row_count_reg;
        col_last = ({1'b0, c_cur} == w_eff - 1'b1);
        row_last = ({1'b0, r_cur} == h_eff - 1'b1);
        if (col_last) begin
            col_count_next = '0;
            row_count_next = row_last ? '0 : r_cur + 1'b1;
        end else begin
            col_count_next = c_cur + 1'b1;
            row_count_next = r_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            if (s_accept) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                // word written back this cycle is missed by the read issued alongside it
                fwd_hit_reg   <= s1_valid_reg && (s1_addr_reg == c_cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg   <= s_pixel;
            s1_addr_reg  <= c_cur;
            s1_emit_reg  <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
            s1_last_reg  <= col_last && row_last;
            fwd_data_reg <= wr_word;
        end
    end

    sem_line_ram #(
        .DATA_W (LINE_W),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word),
        .rd_en   (s_accept),
        .rd_addr (c_cur),
        .rd_data (ram_q)
    );

    // filter stage: upper byte is two rows up, lower byte one row up
    assign line_q  = fwd_hit_reg ? fwd_data_reg : ram_q;
    assign t2      = line_q[LINE_W-1:PIX_W];
    assign m2      = line_q[PIX_W-1:0];
    assign b2      = s1_pix_reg;
    assign wr_word = {m2, s1_pix_reg};

    always_comb begin
        gx_a  = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
        gx_b  = {2'b00, t0_reg} + {1'b0, m0_reg, 1'b0} + {2'b00, b0_reg};
        gy_a  = {2'b00, b0_reg} + {1'b0, b1_reg, 1'b0} + {2'b00, b2};
        gy_b  = {2'b00, t0_reg} + {1'b0, t1_reg, 1'b0} + {2'b00, t2};
        abs_x = (gx_a >= gx_b) ? gx_a - gx_b : gx_b - gx_a;
        abs_y = (gy_a >= gy_b) ? gy_a - gy_b : gy_b - gy_a;
        mag   = {1'b0, abs_x} + {1'b0, abs_y};
        res.edge_res      = (mag > (SUM_W+1)'(SAT_MAX)) ? PIX_W'(SAT_MAX) : mag[PIX_W-1:0];
        res.last_in_frame = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_reg <= '0;
            m0_reg <= '0;
            b0_reg <= '0;
            t1_reg <= '0;
            m1_reg <= '0;
            b1_reg <= '0;
        end else if (s1_valid_reg) begin
            t0_reg <= t1_reg;
            m0_reg <= m1_reg;
            b0_reg <= b1_reg;
            t1_reg <= t2;
            m1_reg <= m2;
            b1_reg <= b2;
        end
    end

    assign res_push = s1_valid_reg && s1_emit_reg;
    assign res_pop  = m_valid && m_ready;

    sem_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .pop       (res_pop),
        .pop_data  (out_data),
        .count     (fifo_count)
    );

    assign m_valid         = (fifo_count != '0);
    assign m_edge_res      = out_data.edge_res;
    assign m_last_in_frame = out_data.last_in_frame;

`ifndef ASSERT_OFF
    // the queue always has room for the result in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH)) || res_pop)
        else $error("result queue overflow");

    // a transfer in reaches the filter stage in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted pixel lost before filter stage");

    // a read of the column being written back picks up the forwarded word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s1_valid_reg && (s1_addr_reg == c_cur)) |=> fwd_hit_reg)
        else $error("line store forwarding missed");

    // an accepted last-of-frame pixel is followed by a restart of the counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && col_last && row_last) |=> (col_count_reg == '0) && (row_count_reg == '0))
        else $error("counters did not wrap at end of frame");
`endif

endmodule
